// ===== rtl/core/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared codes, controller states and command/status bundles of the
// multipart boundary splitter.
// ----------------------------------------------------------------------------
package mbs_pkg;

    // Request mode codes
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_CONTENT = 2'd2;

    // Result kind codes
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FOUND = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FLUSH,
        S_PASS,
        S_FOUND
    } state_t;

    // Boundary store read address source
    typedef enum logic [1:0] {
        RD_MATCH,
        RD_ZERO,
        RD_NEXT
    } rd_sel_t;

    // Result payload source
    typedef enum logic [1:0] {
        PUSH_DATA,
        PUSH_VALUE,
        PUSH_FOUND
    } push_sel_t;

    typedef struct packed {
        logic      clear;
        logic      append;
        logic      load_value;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      idx_clr;
        logic      idx_inc;
        logic      hit_load;
        logic      match_inc;
        logic      match_zero;
        logic      match_set_one;
        logic      set_finished;
        logic      push;
        push_sel_t push_sel;
        logic      push_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic len_one;
        logic finished;
        logic cmp_hit;
        logic last_match;
        logic match_zero;
        logic flush_last;
        logic retry_hit;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/mbs_if.sv =====
// ----------------------------------------------------------------------------
// mbs_if
// Request and result channels of the multipart boundary splitter.
// ----------------------------------------------------------------------------
interface mbs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mbs_rsp_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       last_of_run;

    modport source (output valid, output kind, output data_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input last_of_run,
                    output ready);
endinterface

// ===== rtl/core/multipart_boundary_splitter.sv =====
// ----------------------------------------------------------------------------
// multipart_boundary_splitter
// Scans content bytes for a loaded boundary string, holds back a partial
// match and releases it on a mismatch, and reports the completed match.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  req     | in  | valid/ready  | mode[1:0], value[7:0]
//  rsp     | out | valid/ready  | kind, data_byte[7:0], last_of_run
//
//  Clear, append, ignored content and unused modes finish in the idle state;
//  content with an empty boundary goes on to a pass result. Other content is
//  compared, then each held byte is released in turn, then a pass or found
//  result follows where due. Reset clears counters and controller; the
//  boundary store is not cleared. A stalled rsp holds the push state; req is
//  taken again once the item's last result sits in the one-entry result register.
// ----------------------------------------------------------------------------
module multipart_boundary_splitter
#(
    parameter int BOUNDARY_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    mbs_req_if.sink   req,
    mbs_rsp_if.source rsp
);

    mbs_pkg::ctrl_cmd_t cmd;
    mbs_pkg::ctrl_sts_t sts;

    // sequence the item: accept, compare, release prefix, push results
    mbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold boundary, counters and the result register
    mbs_dp #(
        .BOUNDARY_DEPTH (BOUNDARY_DEPTH)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .value (req.value),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    // never push into an occupied result register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed while result register occupied");

    // a found result always closes its run
    a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind == mbs_pkg::KIND_FOUND)) |-> rsp.last_of_run)
        else $error("found result without last_of_run");

    // a found result carries a zero byte
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind == mbs_pkg::KIND_FOUND)) |-> (rsp.data_byte == 8'd0))
        else $error("found result with non-zero data byte");

    // finishing only happens together with the found push
    a_finish_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_finished |-> (cmd.push && (cmd.push_sel == mbs_pkg::PUSH_FOUND)))
        else $error("finished set without a found result");

    // after a push the result register is occupied
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> rsp.valid)
        else $error("pushed result not presented");

endmodule

// ===== rtl/core/mbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbs_ctrl
// Controller state machine: takes requests, steps the compare, the prefix
// release and the result pushes of the datapath.
// ----------------------------------------------------------------------------
module mbs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_mode,
    output logic               req_ready,
    input  mbs_pkg::ctrl_sts_t sts,
    output mbs_pkg::ctrl_cmd_t cmd
);

    mbs_pkg::state_t state_reg;
    mbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;

        unique case (state_reg)
            mbs_pkg::S_IDLE:
            begin
                req_ready  = 1'b1;
                // keep the entry at the match position fetched
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mbs_pkg::RD_MATCH;
                if (req_valid)
                begin
                    cmd.load_value = 1'b1;
                    unique case (req_mode)
                        mbs_pkg::MODE_CLEAR:  cmd.clear  = 1'b1;
                        mbs_pkg::MODE_APPEND: cmd.append = 1'b1;
                        mbs_pkg::MODE_CONTENT:
                        begin
                            if (!sts.finished)
                            begin
                                state_next = sts.len_zero ? mbs_pkg::S_PASS
                                                          : mbs_pkg::S_CMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            mbs_pkg::S_CMP:
            begin
                if (sts.cmp_hit)
                begin
                    if (sts.last_match)
                    begin
                        state_next = mbs_pkg::S_FOUND;
                    end
                    else
                    begin
                        cmd.match_inc = 1'b1;
                        state_next    = mbs_pkg::S_IDLE;
                    end
                end
                else if (sts.match_zero)
                begin
                    state_next = mbs_pkg::S_PASS;
                end
                else
                begin
                    // start the release at the first boundary byte
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = mbs_pkg::RD_ZERO;
                    cmd.idx_clr = 1'b1;
                    state_next  = mbs_pkg::S_FLUSH;
                end
            end

            mbs_pkg::S_FLUSH:
            begin
                cmd.hit_load = 1'b1;
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = mbs_pkg::PUSH_DATA;
                    cmd.push_last = sts.flush_last && sts.retry_hit && !sts.len_one;
                    if (sts.flush_last)
                    begin
                        if (sts.retry_hit && sts.len_one)
                        begin
                            cmd.match_zero = 1'b1;
                            state_next     = mbs_pkg::S_FOUND;
                        end
                        else if (sts.retry_hit)
                        begin
                            cmd.match_set_one = 1'b1;
                            state_next        = mbs_pkg::S_IDLE;
                        end
                        else
                        begin
                            cmd.match_zero = 1'b1;
                            state_next     = mbs_pkg::S_PASS;
                        end
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = mbs_pkg::RD_NEXT;
                        cmd.idx_inc = 1'b1;
                    end
                end
            end

            mbs_pkg::S_PASS:
            begin
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = mbs_pkg::PUSH_VALUE;
                    cmd.push_last = 1'b1;
                    state_next    = mbs_pkg::S_IDLE;
                end
            end

            mbs_pkg::S_FOUND:
            begin
                if (sts.out_free)
                begin
                    cmd.push         = 1'b1;
                    cmd.push_sel     = mbs_pkg::PUSH_FOUND;
                    cmd.push_last    = 1'b1;
                    cmd.set_finished = 1'b1;
                    state_next       = mbs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mbs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mbs_dp.sv =====
// ----------------------------------------------------------------------------
// mbs_dp
// Datapath: boundary store, length and match counters, release index and
// the one-entry result register.
// ----------------------------------------------------------------------------
module mbs_dp
#(
    parameter int BOUNDARY_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         value,
    input  mbs_pkg::ctrl_cmd_t cmd,
    output mbs_pkg::ctrl_sts_t sts,
    mbs_rsp_if.source          rsp
);

    localparam int AW = (BOUNDARY_DEPTH > 1) ? $clog2(BOUNDARY_DEPTH) : 1;
    localparam int LW = $clog2(BOUNDARY_DEPTH + 1);

    logic [7:0]    mem [0:BOUNDARY_DEPTH-1];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [7:0]    value_reg;
    logic [LW-1:0] length_reg;
    logic [LW-1:0] match_count_reg;
    logic          finished_reg;
    logic [AW-1:0] flush_idx_reg;
    logic          first_hit_reg;
    logic          cmp_now;
    logic          out_valid_reg;
    logic          kind_reg;
    logic [7:0]    data_reg;
    logic          last_reg;

    assign cmp_now = (rd_data_reg == value_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            mbs_pkg::RD_MATCH: rd_addr = match_count_reg[AW-1:0];
            mbs_pkg::RD_NEXT:  rd_addr = flush_idx_reg + AW'(1);
            default:           rd_addr = '0;
        endcase
    end

    // boundary store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.append && (length_reg < LW'(BOUNDARY_DEPTH)))
        begin
            mem[length_reg[AW-1:0]] <= value;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.load_value)
        begin
            value_reg <= value;
        end
        if (cmd.idx_clr)
        begin
            flush_idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            flush_idx_reg <= flush_idx_reg + AW'(1);
        end
        if (cmd.hit_load && (flush_idx_reg == '0))
        begin
            first_hit_reg <= cmp_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg      <= '0;
            match_count_reg <= '0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                length_reg      <= '0;
                match_count_reg <= '0;
                finished_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.append && (length_reg < LW'(BOUNDARY_DEPTH)))
                begin
                    length_reg <= length_reg + LW'(1);
                end
                if (cmd.match_inc)
                begin
                    match_count_reg <= match_count_reg + LW'(1);
                end
                else if (cmd.match_set_one)
                begin
                    match_count_reg <= LW'(1);
                end
                else if (cmd.match_zero)
                begin
                    match_count_reg <= '0;
                end
                if (cmd.set_finished)
                begin
                    finished_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            last_reg <= cmd.push_last;
            case (cmd.push_sel)
                mbs_pkg::PUSH_DATA:
                begin
                    kind_reg <= mbs_pkg::KIND_DATA;
                    data_reg <= rd_data_reg;
                end
                mbs_pkg::PUSH_VALUE:
                begin
                    kind_reg <= mbs_pkg::KIND_DATA;
                    data_reg <= value_reg;
                end
                default:
                begin
                    kind_reg <= mbs_pkg::KIND_FOUND;
                    data_reg <= '0;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = kind_reg;
    assign rsp.data_byte   = data_reg;
    assign rsp.last_of_run = last_reg;

    assign sts.len_zero   = (length_reg == '0);
    assign sts.len_one    = (length_reg == LW'(1));
    assign sts.finished   = finished_reg;
    assign sts.cmp_hit    = cmp_now;
    assign sts.last_match = ((match_count_reg + LW'(1)) == length_reg);
    assign sts.match_zero = (match_count_reg == '0);
    assign sts.flush_last = ((LW'(flush_idx_reg) + LW'(1)) == match_count_reg);
    assign sts.retry_hit  = (flush_idx_reg == '0) ? cmp_now : first_hit_reg;
    assign sts.out_free   = !out_valid_reg || rsp.ready;

endmodule
